// ===== rtl/sfpd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfpd_pkg
// Shared types and constants of the sync-framed packet deframer.
// ----------------------------------------------------------------------------
package sfpd_pkg;

  localparam int BYTE_W   = 8;
  localparam int INDEX_W  = 6;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;

  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'h81;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'hA1;

  typedef enum logic [STATUS_W-1:0] {
    ST_GOOD     = 2'd0,
    ST_BAD_SYNC = 2'd1,
    ST_BAD_LOW  = 2'd2,
    ST_BAD_HIGH = 2'd3
  } status_t;

  typedef struct packed {
    logic    clr_sums;
    logic    data_wr;
    logic    err_load;
    status_t err_code;
    logic    emit_clr;
    logic    rd_en;
    logic    emit_load;
    logic    emit_inc;
  } cmd_t;

  typedef struct packed {
    logic sync1_hit;
    logic sync2_hit;
    logic ck_low_ok;
    logic ck_high_ok;
    logic count_last;
    logic emit_last;
    logic load_ok;
  } sts_t;

endpackage

// ===== rtl/sync_framed_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// sync_framed_packet_deframer
// Deframes two-sync-byte fixed-length frames with a two-sum checksum.
//
// Channel  Direction  Payload
// in_      slave      tdata[7:0] rx_byte
// out_     master     tdata[7:0] payload_byte, [13:8] byte_index, [15:14] zero;
//                     tuser[1:0] status; tlast last_of_run
// cfg_     write      index 0 sync_first, index 1 sync_second
//
// Received bytes are taken without stalls while a frame is being parsed.
// An error word is loaded in S_ERR, which waits if the output register is full.
// A good frame emits its payload byte by byte: each is read through the store's
// registered read port in S_RD and loaded in S_WR, which waits on output stalls.
// Input is held off while an error word or a payload run is being sent.
// Reset is synchronous; the payload store needs no clearing pass.
// ----------------------------------------------------------------------------
module sync_framed_packet_deframer
  import sfpd_pkg::*;
#(
  parameter int PAYLOAD_BYTES = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [BYTE_W-1:0]     cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [BYTE_W-1:0]     in_tdata,   // rx_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // payload_byte, byte_index
  output logic [STATUS_W-1:0]   out_tuser,  // status
  output logic                  out_tlast   // last_of_run
);

  cmd_t cmd;
  sts_t sts;

  sfpd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sfpd_dp #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== rtl/sfpd_ram.sv =====
// ----------------------------------------------------------------------------
// sfpd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sfpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/sfpd_ctrl.sv =====
// ----------------------------------------------------------------------------
// sfpd_ctrl
// Frame parser state machine: hunts sync, collects payload, checks the sums
// and sequences the error word or the payload run.
// ----------------------------------------------------------------------------
module sfpd_ctrl
  import sfpd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SYNC2,
    S_DATA,
    S_CKL,
    S_CKH,
    S_ERR,
    S_RD,
    S_WR
  } state_t;

  state_t  state_r, state_nxt;
  status_t err_code_r, err_code_nxt;
  logic    in_acc;

  assign in_tready = (state_r == S_IDLE) || (state_r == S_SYNC2) || (state_r == S_DATA) ||
                     (state_r == S_CKL) || (state_r == S_CKH);
  assign in_acc = in_tvalid && in_tready;

  always_comb begin
    state_nxt    = state_r;
    err_code_nxt = err_code_r;
    cmd          = '0;
    cmd.err_code = err_code_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && sts.sync1_hit) begin
          state_nxt = S_SYNC2;
        end
      end
      S_SYNC2: begin
        if (in_acc) begin
          cmd.clr_sums = 1'b1;
          if (sts.sync2_hit) begin
            state_nxt = S_DATA;
          end else begin
            err_code_nxt = ST_BAD_SYNC;
            state_nxt    = S_ERR;
          end
        end
      end
      S_DATA: begin
        if (in_acc) begin
          cmd.data_wr = 1'b1;
          if (sts.count_last) begin
            state_nxt = S_CKL;
          end
        end
      end
      S_CKL: begin
        if (in_acc) begin
          if (sts.ck_low_ok) begin
            state_nxt = S_CKH;
          end else begin
            err_code_nxt = ST_BAD_LOW;
            state_nxt    = S_ERR;
          end
        end
      end
      S_CKH: begin
        if (in_acc) begin
          if (sts.ck_high_ok) begin
            cmd.emit_clr = 1'b1;
            state_nxt    = S_RD;
          end else begin
            err_code_nxt = ST_BAD_HIGH;
            state_nxt    = S_ERR;
          end
        end
      end
      S_ERR: begin
        if (sts.load_ok) begin
          cmd.err_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        if (sts.load_ok) begin
          cmd.emit_load = 1'b1;
          if (sts.emit_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.emit_inc = 1'b1;
            state_nxt    = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      err_code_r <= ST_GOOD;
    end else begin
      state_r    <= state_nxt;
      err_code_r <= err_code_nxt;
    end
  end

endmodule

// ===== rtl/sfpd_dp.sv =====
// ----------------------------------------------------------------------------
// sfpd_dp
// Datapath: sync registers, running sums, payload store and the output
// register of the result channel.
// ----------------------------------------------------------------------------
module sfpd_dp
  import sfpd_pkg::*;
#(
  parameter int PAYLOAD_BYTES = 32,
  localparam int AW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [BYTE_W-1:0]     cfg_wdata,
  input  logic [BYTE_W-1:0]     in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [STATUS_W-1:0]   out_tuser,
  output logic                  out_tlast,
  input  cmd_t                  cmd,
  output sts_t                  sts
);

  localparam logic [AW-1:0] LAST_IDX = AW'(PAYLOAD_BYTES - 1);

  logic [BYTE_W-1:0]     sync_first_r, sync_second_r;
  logic [BYTE_W-1:0]     sum_low_r, sum_low_nxt, sum_high_r, sum_high_nxt;
  logic [AW-1:0]         count_r, emit_idx_r;
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  status_t               out_tuser_r;
  logic                  out_tlast_r;
  logic [BYTE_W-1:0]     rd_data;

  assign sum_low_nxt  = sum_low_r + in_tdata;
  assign sum_high_nxt = sum_high_r + sum_low_nxt;

  assign sts.sync1_hit  = (in_tdata == sync_first_r);
  assign sts.sync2_hit  = (in_tdata == sync_second_r);
  assign sts.ck_low_ok  = (in_tdata == sum_low_r);
  assign sts.ck_high_ok = (in_tdata == sum_high_r);
  assign sts.count_last = (count_r == LAST_IDX);
  assign sts.emit_last  = (emit_idx_r == LAST_IDX);
  assign sts.load_ok    = !out_tvalid_r || out_tready;

  sfpd_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(PAYLOAD_BYTES)
  ) u_store (
    .clk    (clk),
    .wr_en  (cmd.data_wr),
    .wr_addr(count_r),
    .wr_data(in_tdata),
    .rd_en  (cmd.rd_en),
    .rd_addr(emit_idx_r),
    .rd_data(rd_data)
  );

  always_comb begin
    if (cmd.err_load || cmd.emit_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end else begin
      out_tvalid_nxt = out_tvalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= SYNC_FIRST_RST;
      sync_second_r <= SYNC_SECOND_RST;
      sum_low_r     <= '0;
      sum_high_r    <= '0;
      count_r       <= '0;
      emit_idx_r    <= '0;
      out_tvalid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_SYNC_FIRST:  sync_first_r  <= cfg_wdata;
          CFG_SYNC_SECOND: sync_second_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.clr_sums) begin
        sum_low_r  <= '0;
        sum_high_r <= '0;
        count_r    <= '0;
      end else if (cmd.data_wr) begin
        sum_low_r  <= sum_low_nxt;
        sum_high_r <= sum_high_nxt;
        count_r    <= count_r + AW'(1);
      end
      if (cmd.emit_clr) begin
        emit_idx_r <= '0;
      end else if (cmd.emit_inc) begin
        emit_idx_r <= emit_idx_r + AW'(1);
      end
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.err_load) begin
      out_tdata_r <= '0;
      out_tuser_r <= cmd.err_code;
      out_tlast_r <= 1'b1;
    end else if (cmd.emit_load) begin
      out_tdata_r <= OUT_DATA_W'({INDEX_W'(emit_idx_r), rd_data});
      out_tuser_r <= ST_GOOD;
      out_tlast_r <= sts.emit_last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.err_load && cmd.emit_load))
    else $error("Error word and payload word loaded together.");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.err_load || cmd.emit_load) |-> sts.load_ok)
    else $error("Output register overwritten while a word waits.");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.err_load || cmd.emit_load) |=> out_tvalid_r)
    else $error("Loaded word not presented.");

  a_last_run: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_load && sts.emit_last) |=> out_tlast_r)
    else $error("Final payload word not marked last.");

endmodule
